FILE: design/tkf_pkg.sv
// Shared types, constants and register indexes for the top-K frequency block.
package tkf_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int MAX_TOP_DEF       = 16;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 16;
  localparam int RANK_W  = 4;
  localparam int TOPC_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [VALUE_W-1:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [TOPC_W-1:0]  TOP_COUNT_RST = 5'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TOP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_ZERO = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_SELECT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;     // capture input beat, restart the rank sequence
    logic scan_clear;  // rewind the table scan
    logic scan_run;    // step the table scan
    logic select_mode; // scan ranks entries rather than matching the input
    logic update;      // write back the count or a new entry
    logic emit_load;   // move the best entry into the output register
  } cmd_t;

  typedef struct packed {
    logic skip_item;
    logic scan_done;
    logic out_free;
    logic last_rank;
  } stat_t;

endpackage

FILE: design/tkf_ram.sv
// Generic single write port RAM with a registered read port.
module tkf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/tkf_ctrl.sv
// Controller state machine sequencing lookup, update, ranking and output.
module tkf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tkf_pkg::stat_t stat,
  output tkf_pkg::cmd_t  cmd
);
  import tkf_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid && !stat.skip_item) state_nxt = ST_LOOKUP;
      ST_LOOKUP: if (stat.scan_done) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_SELECT;
      ST_SELECT: if (stat.scan_done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (stat.out_free) state_nxt = stat.last_rank ? ST_IDLE : ST_SELECT;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_in    = in_valid && !stat.skip_item;
        cmd.scan_clear = 1'b1;
      end
      ST_LOOKUP: cmd.scan_run = 1'b1;
      ST_UPDATE: begin
        cmd.update     = 1'b1;
        cmd.scan_clear = 1'b1;
      end
      ST_SELECT: begin
        cmd.scan_run    = 1'b1;
        cmd.select_mode = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit_load  = stat.out_free;
        cmd.scan_clear = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: design/tkf_dp.sv
// Datapath: configuration, entry table, scan pipeline, ranking and output register.
module tkf_dp #(
  parameter int TABLE_ENTRIES = tkf_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_TOP       = tkf_pkg::MAX_TOP_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tkf_pkg::cmd_t                       cmd,
  output tkf_pkg::stat_t                      stat,
  input  logic signed [tkf_pkg::VALUE_W-1:0]  in_value,
  input  logic                                cfg_valid,
  input  logic [tkf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tkf_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tkf_pkg::VALUE_W-1:0]  out_ranked_value,
  output logic [tkf_pkg::COUNT_W-1:0]         out_occurrences,
  output logic [tkf_pkg::RANK_W-1:0]          out_rank,
  output logic                                out_last_of_list,
  output logic                                out_table_overflow
);
  import tkf_pkg::*;

  localparam int AW    = $clog2(TABLE_ENTRIES);
  localparam int CW    = $clog2(TABLE_ENTRIES + 1);
  localparam int KW    = $clog2(MAX_TOP + 1);
  localparam int RW    = $clog2(MAX_TOP + 1);
  localparam int EW    = VALUE_W + COUNT_W;
  localparam int KEY_W = COUNT_W + VALUE_W;

  // Configuration registers.
  logic [TOPC_W-1:0] top_count_r;
  logic              skip_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= TOP_COUNT_RST;
      skip_zero_r <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_TOP_COUNT) top_count_r <= cfg_data[TOPC_W-1:0];
      if (cfg_index == CFG_SKIP_ZERO) skip_zero_r <= cfg_data[0];
    end
  end

  // Entry table: value in the upper bits, count in the lower.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  tkf_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [VALUE_W-1:0] rd_val;
  logic [COUNT_W-1:0] rd_cnt;
  assign rd_val = ram_rdata[EW-1:COUNT_W];
  assign rd_cnt = ram_rdata[COUNT_W-1:0];

  logic [CW-1:0]      used_r;
  logic               ovf_r;
  logic [VALUE_W-1:0] val_r;
  logic               found_r;
  logic [AW-1:0]      found_idx_r;
  logic [COUNT_W-1:0] found_cnt_r;

  // Scan pipeline: one read issued per cycle, its data checked in the following cycle.
  logic [CW-1:0] scan_cnt_r;
  logic          pend_r;
  logic          rd_issue;

  assign rd_issue  = cmd.scan_run && (scan_cnt_r < used_r);
  assign ram_raddr = scan_cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      pend_r     <= 1'b0;
    end else if (cmd.scan_clear) begin
      scan_cnt_r <= '0;
      pend_r     <= 1'b0;
    end else begin
      pend_r <= rd_issue;
      if (rd_issue) scan_cnt_r <= scan_cnt_r + 1'b1;
    end
  end

  logic [AW-1:0] pend_idx_r;
  always_ff @(posedge clk) begin
    pend_idx_r <= scan_cnt_r[AW-1:0];
  end

  // Lookup and write back.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = used_r[AW-1:0];
    ram_wdata = {val_r, COUNT_W'(1)};
    if (cmd.update) begin
      if (found_r) begin
        ram_we    = 1'b1;
        ram_waddr = found_idx_r;
        ram_wdata = {val_r, (found_cnt_r == COUNT_MAX) ? COUNT_MAX : found_cnt_r + 1'b1};
      end else if (32'(used_r) < TABLE_ENTRIES) begin
        ram_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      ovf_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (cmd.load_in) found_r <= 1'b0;
      else if (!cmd.select_mode && pend_r && rd_val == val_r) found_r <= 1'b1;
      if (cmd.update && !found_r) begin
        if (32'(used_r) < TABLE_ENTRIES) used_r <= used_r + 1'b1;
        else ovf_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) val_r <= in_value;
    if (!cmd.select_mode && pend_r && rd_val == val_r) begin
      found_idx_r <= pend_idx_r;
      found_cnt_r <= rd_cnt;
    end
  end

  // Ranking: each rank takes the highest key strictly below the last one reported.
  logic [KEY_W-1:0]   rd_key, best_key_r, bound_key_r;
  logic               have_best_r, bound_valid_r;
  logic [VALUE_W-1:0] best_val_r;
  logic [COUNT_W-1:0] best_cnt_r;
  logic [RW-1:0]      rank_r;
  logic               take;

  assign rd_key = {rd_cnt, ~(rd_val ^ SIGN_BIT)};
  assign take   = cmd.select_mode && pend_r
                  && (!bound_valid_r || rd_key < bound_key_r)
                  && (!have_best_r || rd_key > best_key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r   <= 1'b0;
      bound_valid_r <= 1'b0;
      rank_r        <= '0;
    end else if (cmd.load_in) begin
      have_best_r   <= 1'b0;
      bound_valid_r <= 1'b0;
      rank_r        <= '0;
    end else if (cmd.emit_load) begin
      have_best_r   <= 1'b0;
      bound_valid_r <= 1'b1;
      rank_r        <= rank_r + 1'b1;
    end else if (take) begin
      have_best_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) bound_key_r <= best_key_r;
    if (take) begin
      best_key_r <= rd_key;
      best_val_r <= rd_val;
      best_cnt_r <= rd_cnt;
    end
  end

  // Effective K, clamped to one through MAX_TOP.
  logic [KW-1:0] k_top;
  always_comb begin
    priority if (top_count_r == '0)          k_top = KW'(1);
    else if (32'(top_count_r) > MAX_TOP)     k_top = KW'(MAX_TOP);
    else                                     k_top = KW'(top_count_r);
  end

  logic last_rank;
  assign last_rank = (32'(rank_r) + 1 == 32'(k_top)) || (32'(rank_r) + 1 == 32'(used_r));

  // Output register.
  logic               out_valid_r;
  logic [VALUE_W-1:0] out_val_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic [RANK_W-1:0]  out_rank_r;
  logic               out_last_r, out_ovf_r;
  logic [31:0]        rank_ext;

  assign rank_ext = 32'(rank_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_val_r  <= best_val_r;
      out_cnt_r  <= best_cnt_r;
      out_rank_r <= rank_ext[RANK_W-1:0];
      out_last_r <= last_rank;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ranked_value   = out_val_r;
  assign out_occurrences    = out_cnt_r;
  assign out_rank           = out_rank_r;
  assign out_last_of_list   = out_last_r;
  assign out_table_overflow = out_ovf_r;

  assign stat.skip_item = skip_zero_r && (in_value == '0);
  assign stat.scan_done = cmd.scan_run && !pend_r && (scan_cnt_r == used_r);
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.last_rank = last_rank;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= TABLE_ENTRIES) else $error("entry count above table size");
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(ovf_r) |-> ovf_r) else $error("overflow flag cleared");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> (!out_valid_r || out_ready)) else $error("result overwritten");
  a_emit_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> have_best_r) else $error("result loaded without a candidate");

endmodule

FILE: design/top_k_frequent_stream_top.sv
// Top level of the streaming top-K frequent value block.
//
// Each input beat carries one signed 32-bit value. The block counts it in a
// table of distinct values, then delivers a list of result beats, the most
// frequent held values first, smaller value first on equal counts. The final
// beat of each list carries last_of_list. With skip_zero set, a zero input is
// taken and produces no beats.
// Configuration beats (register 0: top_count, register 1: skip_zero) are
// always accepted and must only be sent while the block is idle.
// Sequence: the beat is accepted, a lookup scan runs over the held entries, the
// count or new entry is written back, then for each rank up to K (and up to the
// number of held entries) a ranking scan runs and its result is loaded; each
// scan reads the entries one at a time through the single table read port.
// A new input is accepted once the last result of the previous list has been
// loaded into the output register, even if that beat is still waiting.
// When the receiver stalls, the output register holds its beat and the block
// waits before loading the next rank. Reset empties the table and clears the
// overflow flag; table memory contents are not cleared.
module top_k_frequent_stream_top #(
  parameter int TABLE_ENTRIES = tkf_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_TOP       = tkf_pkg::MAX_TOP_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [tkf_pkg::VALUE_W-1:0] in_value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tkf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tkf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tkf_pkg::VALUE_W-1:0] out_ranked_value,
  output logic [tkf_pkg::COUNT_W-1:0]        out_occurrences,
  output logic [tkf_pkg::RANK_W-1:0]         out_rank,
  output logic                               out_last_of_list,
  output logic                               out_table_overflow
);
  import tkf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Configuration writes never stall.
  assign cfg_ready = 1'b1;

  // The controller only sequences; all data storage sits in the datapath.
  tkf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tkf_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_TOP(MAX_TOP)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_value           (in_value),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ranked_value   (out_ranked_value),
    .out_occurrences    (out_occurrences),
    .out_rank           (out_rank),
    .out_last_of_list   (out_last_of_list),
    .out_table_overflow (out_table_overflow)
  );

endmodule
